/* hw/rtl/saot_pkg.sv */
package saot_pkg;
	localparam int SET_BITS = 9;
	localparam int WAYS = 8;
	localparam int WAY_W = 3;
	localparam int NSETS = 1 << SET_BITS;
	localparam int FILL_W = 4;
	localparam logic [63:0] MUL64 = 64'h9E3779B97F4A7C15;
	localparam logic [31:0] MUL64_LO = 32'h7F4A7C15;
	localparam logic [31:0] MUL64_HI = 32'h9E3779B9;
	localparam logic [31:0] MUL32 = 32'h9E3779B9;

	localparam logic [1:0] HASH_RAW = 2'd0;
	localparam logic [1:0] HASH_MUL64 = 2'd1;
	localparam logic [1:0] HASH_FOLD = 2'd2;
	localparam logic [1:0] HASH_MUL32 = 2'd3;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_DECR = 2'd2;
	localparam logic [1:0] CMD_REPLACE = 2'd3;

	localparam logic [3:0] ST_INSERTED = 4'd0;
	localparam logic [3:0] ST_OVERFLOW = 4'd1;
	localparam logic [3:0] ST_FILTERED = 4'd2;
	localparam logic [3:0] ST_DELETED = 4'd3;
	localparam logic [3:0] ST_DECR = 4'd4;
	localparam logic [3:0] ST_DECR_RM = 4'd5;
	localparam logic [3:0] ST_MISS = 4'd6;
	localparam logic [3:0] ST_REPLACED = 4'd7;
	localparam logic [3:0] ST_REPL_OVF = 4'd8;
	localparam logic [3:0] ST_INVALID = 4'd9;

	localparam logic [1:0] REG_HASH = 2'd0;
	localparam logic [1:0] REG_SETBITS = 2'd1;
	localparam logic [1:0] REG_FEN = 2'd2;
	localparam logic [1:0] REG_FLOC = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [63:0] order_id;
		logic [31:0] quantity;
		logic [63:0] new_ref;
		logic early;
		logic [3:0] early_status;
	} cmd_t;

	typedef struct packed {
		logic [3:0] status;
		logic [8:0] set_index;
		logic [2:0] way_index;
		logic [31:0] qty_left;
		logic [12:0] live_count;
		logic [12:0] peak_count;
		logic [3:0] max_set_occupancy;
		logic [31:0] overflow_count;
		logic [31:0] miss_count;
	} res_t;
endpackage

/* hw/rtl/set_associative_order_table.sv */
// A lookup or insert steps through the states S_MUL and S_HASH (the hash), S_READ (the row read)
// and S_EXEC (the row write and the result); a replace that finds its entry runs them a second
// time for new_ref, and a filtered or invalid transaction is answered straight from S_IDLE.
// The back end takes one transaction at a time and accepts the next only after the result is taken.
// Reset: arst_n clears statistics and registers, then a clearing pass over all 512 sets empties
// the table; up to two transactions are queued meanwhile and carried out after it.
module set_associative_order_table (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] command,
	input logic [63:0] order_id,
	input logic [31:0] quantity,
	input logic [63:0] new_ref,
	input logic [15:0] locate,
	output logic out_valid,
	input logic out_ready,
	output logic [3:0] status,
	output logic [8:0] set_index,
	output logic [2:0] way_index,
	output logic [31:0] qty_left,
	output logic [12:0] live_count,
	output logic [12:0] peak_count,
	output logic [3:0] max_set_occupancy,
	output logic [31:0] overflow_count,
	output logic [31:0] miss_count,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	logic [1:0] hash_mode_q;
	logic [3:0] set_bits_q;
	logic fen_q;
	logic [15:0] floc_q;
	logic q_valid, q_ready;
	saot_pkg::cmd_t q_data;
	saot_pkg::res_t r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mode_q <= saot_pkg::HASH_FOLD;
			set_bits_q <= 4'd9;
			fen_q <= 1'b0;
			floc_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				saot_pkg::REG_HASH: hash_mode_q <= cfg_data[1:0];
				saot_pkg::REG_SETBITS: set_bits_q <= cfg_data[3:0];
				saot_pkg::REG_FEN: fen_q <= cfg_data[0];
				saot_pkg::REG_FLOC: floc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	saot_front u_front (.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready),
		.command(command), .order_id(order_id), .quantity(quantity), .new_ref(new_ref),
		.locate(locate), .filter_enable(fen_q), .filter_locate(floc_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data));

	saot_back u_back (.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_data(q_data), .hash_mode(hash_mode_q), .set_bits(set_bits_q),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(r));

	assign status = r.status;
	assign set_index = r.set_index;
	assign way_index = r.way_index;
	assign qty_left = r.qty_left;
	assign live_count = r.live_count;
	assign peak_count = r.peak_count;
	assign max_set_occupancy = r.max_set_occupancy;
	assign overflow_count = r.overflow_count;
	assign miss_count = r.miss_count;
endmodule

/* hw/rtl/saot_front.sv */
module saot_front (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic ready,
	input logic [1:0] command,
	input logic [63:0] order_id,
	input logic [31:0] quantity,
	input logic [63:0] new_ref,
	input logic [15:0] locate,
	input logic filter_enable,
	input logic [15:0] filter_locate,
	output logic q_valid,
	input logic q_ready,
	output saot_pkg::cmd_t q_data
);
	localparam int DEPTH = 2;
	saot_pkg::cmd_t mem_q [DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	saot_pkg::cmd_t c;
	logic push, pop;

	always_comb begin
		c.command = command;
		c.order_id = order_id;
		c.quantity = quantity;
		c.new_ref = new_ref;
		c.early = 1'b0;
		c.early_status = saot_pkg::ST_INVALID;
		if (command == saot_pkg::CMD_INSERT && filter_enable && locate != filter_locate) begin
			c.early = 1'b1;
			c.early_status = saot_pkg::ST_FILTERED;
		end else if (order_id == 64'd0 ||
			(command == saot_pkg::CMD_REPLACE && new_ref == 64'd0)) begin
			c.early = 1'b1;
		end
	end

	assign ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rp_q];
	assign push = valid && ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* hw/rtl/saot_hash.sv */
module saot_hash (
	input logic clk,
	input logic [63:0] key,
	input logic [1:0] hash_mode,
	input logic [3:0] eff_bits,
	output logic [8:0] set_s2
);
	logic [63:0] lo_s1;
	logic [31:0] cross_a_s1, cross_b_s1;
	logic [8:0] raw_s1, fold_s1;
	logic [63:0] p32_s1;
	logic [31:0] f32;
	logic [63:0] p64;
	logic [63:0] h;
	logic [9:0] mask;

	assign f32 = key[31:0] ^ key[63:32];

	// The low 64 bits of the 64-bit product are built from three 32-bit products.
	always_ff @(posedge clk) begin
		lo_s1 <= 64'(key[31:0]) * 64'(saot_pkg::MUL64_LO);
		cross_a_s1 <= key[63:32] * saot_pkg::MUL64_LO;
		cross_b_s1 <= key[31:0] * saot_pkg::MUL64_HI;
		p32_s1 <= 64'(f32) * 64'(saot_pkg::MUL32);
		raw_s1 <= key[8:0];
		fold_s1 <= key[8:0] ^ key[24:16] ^ key[40:32] ^ key[56:48];
	end

	assign p64 = lo_s1 + {cross_a_s1 + cross_b_s1, 32'd0};
	assign mask = (10'd1 << eff_bits) - 10'd1;

	always_comb begin
		case (hash_mode)
			saot_pkg::HASH_MUL64: h = p64 >> (7'd64 - {3'd0, eff_bits});
			saot_pkg::HASH_FOLD: h = {55'd0, fold_s1};
			saot_pkg::HASH_MUL32: h = p32_s1 >> (6'd32 - {2'd0, eff_bits});
			default: h = {55'd0, raw_s1};
		endcase
	end

	always_ff @(posedge clk) begin
		set_s2 <= h[8:0] & mask[8:0];
	end
endmodule

/* hw/rtl/saot_back.sv */
module saot_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input saot_pkg::cmd_t q_data,
	input logic [1:0] hash_mode,
	input logic [3:0] set_bits,
	output logic out_valid,
	input logic out_ready,
	output saot_pkg::res_t out_data
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL = 6'b000010,
		S_HASH = 6'b000100,
		S_READ = 6'b001000,
		S_EXEC = 6'b010000,
		S_CLEAR = 6'b100000
	} state_t;

	localparam int ROW_W = saot_pkg::WAYS * 64;
	localparam int QROW_W = saot_pkg::WAYS * 32;

	state_t state_q;
	logic [ROW_W-1:0] ref_mem [saot_pkg::NSETS];
	logic [QROW_W-1:0] qty_mem [saot_pkg::NSETS];
	logic [saot_pkg::FILL_W-1:0] fill_mem [saot_pkg::NSETS];
	logic [ROW_W-1:0] ref_rd_q;
	logic [QROW_W-1:0] qty_rd_q;
	logic [saot_pkg::FILL_W-1:0] fill_rd_q;
	logic [8:0] clr_q;

	saot_pkg::cmd_t cur_q;
	logic second_q;
	logic [8:0] set_q;
	logic [3:0] eff_bits;
	logic [8:0] hset;
	logic [63:0] key;

	logic [12:0] live_q, peak_q;
	logic [3:0] maxocc_q;
	logic [31:0] ovf_q, miss_q;
	logic [63:0] ref_w [saot_pkg::WAYS];
	logic [31:0] qty_w [saot_pkg::WAYS];
	logic [saot_pkg::WAYS-1:0] hit, empty;
	logic [2:0] hit_way, free_way;
	logic any_hit, any_free;

	logic we;
	logic [ROW_W-1:0] ref_wd;
	logic [QROW_W-1:0] qty_wd;
	logic [saot_pkg::FILL_W-1:0] fill_wd;
	logic go_second;
	saot_pkg::res_t res;
	logic [12:0] live_n, peak_n;
	logic [3:0] maxocc_n;
	logic [31:0] ovf_n, miss_n;

	always_comb begin
		eff_bits = set_bits;
		if (set_bits == 4'd0) eff_bits = 4'd1;
		if (set_bits > 4'(saot_pkg::SET_BITS)) eff_bits = 4'(saot_pkg::SET_BITS);
	end

	assign key = second_q ? cur_q.new_ref : cur_q.order_id;
	saot_hash u_hash (.clk(clk), .key(key), .hash_mode(hash_mode), .eff_bits(eff_bits),
		.set_s2(hset));

	always_comb begin
		for (int w = 0; w < saot_pkg::WAYS; w++) begin
			ref_w[w] = ref_rd_q[w*64 +: 64];
			qty_w[w] = qty_rd_q[w*32 +: 32];
			hit[w] = ref_w[w] == cur_q.order_id;
			empty[w] = ref_w[w] == 64'd0;
		end
		hit_way = '0;
		free_way = '0;
		any_hit = 1'b0;
		any_free = 1'b0;
		for (int w = saot_pkg::WAYS - 1; w >= 0; w--) begin
			if (hit[w]) begin hit_way = 3'(w); any_hit = 1'b1; end
			if (empty[w]) begin free_way = 3'(w); any_free = 1'b1; end
		end
	end

	always_comb begin
		we = 1'b0;
		ref_wd = ref_rd_q;
		qty_wd = qty_rd_q;
		fill_wd = fill_rd_q;
		go_second = 1'b0;
		live_n = live_q;
		peak_n = peak_q;
		maxocc_n = maxocc_q;
		ovf_n = ovf_q;
		miss_n = miss_q;
		res = '0;
		res.set_index = set_q;
		if (cur_q.command == saot_pkg::CMD_INSERT || second_q) begin
			if (any_free) begin
				we = 1'b1;
				ref_wd[free_way*64 +: 64] = second_q ? cur_q.new_ref : cur_q.order_id;
				qty_wd[free_way*32 +: 32] = cur_q.quantity;
				fill_wd = fill_rd_q + 4'd1;
				if (fill_wd > maxocc_n) maxocc_n = fill_wd;
				live_n = live_q + 13'd1;
				if (live_n > peak_n) peak_n = live_n;
				res.status = second_q ? saot_pkg::ST_REPLACED : saot_pkg::ST_INSERTED;
				res.way_index = free_way;
				res.qty_left = cur_q.quantity;
			end else begin
				if (ovf_q != '1) ovf_n = ovf_q + 32'd1;
				res.status = second_q ? saot_pkg::ST_REPL_OVF : saot_pkg::ST_OVERFLOW;
			end
		end else if (!any_hit) begin
			if (miss_q != '1) miss_n = miss_q + 32'd1;
			res.status = saot_pkg::ST_MISS;
		end else begin
			res.way_index = hit_way;
			if (cur_q.command == saot_pkg::CMD_DECR && qty_w[hit_way] > cur_q.quantity) begin
				we = 1'b1;
				qty_wd[hit_way*32 +: 32] = qty_w[hit_way] - cur_q.quantity;
				res.qty_left = qty_w[hit_way] - cur_q.quantity;
				res.status = saot_pkg::ST_DECR;
			end else begin
				we = 1'b1;
				ref_wd[hit_way*64 +: 64] = 64'd0;
				if (fill_rd_q != 4'd0) fill_wd = fill_rd_q - 4'd1;
				if (live_q != 13'd0) live_n = live_q - 13'd1;
				res.status = (cur_q.command == saot_pkg::CMD_DELETE) ? saot_pkg::ST_DELETED :
					(cur_q.command == saot_pkg::CMD_DECR) ? saot_pkg::ST_DECR_RM :
					saot_pkg::ST_REPLACED;
				go_second = (cur_q.command == saot_pkg::CMD_REPLACE);
			end
		end
		res.live_count = live_n;
		res.peak_count = peak_n;
		res.max_set_occupancy = maxocc_n;
		res.overflow_count = ovf_n;
		res.miss_count = miss_n;
	end

	assign q_ready = (state_q == S_IDLE) && !out_valid;

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			ref_mem[clr_q] <= '0;
			fill_mem[clr_q] <= '0;
		end else if (state_q == S_EXEC && we) begin
			ref_mem[set_q] <= ref_wd;
			qty_mem[set_q] <= qty_wd;
			fill_mem[set_q] <= fill_wd;
		end
		if (state_q == S_READ) begin
			ref_rd_q <= ref_mem[hset];
			qty_rd_q <= qty_mem[hset];
			fill_rd_q <= fill_mem[hset];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
			cur_q <= '0;
			set_q <= '0;
			second_q <= 1'b0;
			live_q <= '0;
			peak_q <= '0;
			maxocc_q <= '0;
			ovf_q <= '0;
			miss_q <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 9'd1;
					if (clr_q == 9'(saot_pkg::NSETS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid && q_ready) begin
						cur_q <= q_data;
						second_q <= 1'b0;
						if (q_data.early) begin
							out_data <= '{status: q_data.early_status, set_index: '0,
								way_index: '0, qty_left: '0, live_count: live_q,
								peak_count: peak_q, max_set_occupancy: maxocc_q,
								overflow_count: ovf_q, miss_count: miss_q};
							out_valid <= 1'b1;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: state_q <= S_HASH;
				S_HASH: state_q <= S_READ;
				S_READ: begin
					set_q <= hset;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					live_q <= live_n;
					peak_q <= peak_n;
					maxocc_q <= maxocc_n;
					ovf_q <= ovf_n;
					miss_q <= miss_n;
					if (go_second) begin
						second_q <= 1'b1;
						state_q <= S_MUL;
					end else begin
						out_data <= res;
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hw/rtl/saot_checker.sv */
module saot_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [3:0] status,
	input logic [12:0] live_count,
	input logic [12:0] peak_count,
	input logic [31:0] miss_count
);
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> peak_count >= live_count) else $error("peak below live");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result dropped");
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == saot_pkg::ST_MISS |-> miss_count != 32'd0)
		else $error("miss not counted");
endmodule

bind set_associative_order_table saot_checker u_chk (.clk(clk), .arst_n(arst_n),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.live_count(live_count), .peak_count(peak_count), .miss_count(miss_count));

/* tb/order_table_checker.sv */
module order_table_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [1:0] command,
	input logic [63:0] order_id,
	input logic [31:0] quantity,
	input logic [63:0] new_ref,
	input logic [15:0] locate,
	input logic out_valid,
	input logic out_ready,
	input logic [3:0] status,
	input logic [8:0] set_index,
	input logic [2:0] way_index,
	input logic [31:0] qty_left,
	input logic [12:0] live_count,
	input logic [12:0] peak_count,
	input logic [3:0] max_set_occupancy,
	input logic [31:0] overflow_count,
	input logic [31:0] miss_count,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	output int fail_count,
	output int pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [1:0] mdl_hash;
	logic [3:0] mdl_bits;
	logic mdl_fen;
	logic [15:0] mdl_floc;
	logic [63:0] tbl_ref [saot_pkg::NSETS*saot_pkg::WAYS];
	logic [31:0] tbl_qty [saot_pkg::NSETS*saot_pkg::WAYS];
	int tbl_fill [saot_pkg::NSETS];
	int n_live, n_peak, n_fullest;
	logic [31:0] n_dropped, n_missed;
	saot_pkg::res_t expected_results [$];

	assign pending_results = expected_results.size();

	function automatic int set_of(logic [63:0] r);
		int b;
		logic [63:0] h;
		logic [63:0] f;
		b = (mdl_bits < 1) ? 1 : (mdl_bits > saot_pkg::SET_BITS) ? saot_pkg::SET_BITS :
			int'(mdl_bits);
		case (mdl_hash)
			saot_pkg::HASH_MUL64: h = (r * saot_pkg::MUL64) >> (64 - b);
			saot_pkg::HASH_FOLD: h = r ^ (r >> 16) ^ (r >> 32) ^ (r >> 48);
			saot_pkg::HASH_MUL32: begin
				f = {32'd0, r[31:0] ^ r[63:32]};
				h = (f * {32'd0, saot_pkg::MUL32}) >> (32 - b);
			end
			default: h = r;
		endcase
		return int'(h & ((64'd1 << b) - 1));
	endfunction

	function automatic int find_way(int s, logic [63:0] r);
		for (int w = 0; w < saot_pkg::WAYS; w++)
			if (tbl_ref[s*saot_pkg::WAYS+w] == r) return w;
		return -1;
	endfunction

	function automatic void drop_entry(int s, int w);
		tbl_ref[s*saot_pkg::WAYS+w] = '0;
		if (tbl_fill[s] > 0) tbl_fill[s]--;
		if (n_live > 0) n_live--;
	endfunction

	function automatic int store_entry(int s, logic [63:0] r, logic [31:0] q);
		for (int w = 0; w < saot_pkg::WAYS; w++) begin
			if (tbl_ref[s*saot_pkg::WAYS+w] == '0) begin
				tbl_ref[s*saot_pkg::WAYS+w] = r;
				tbl_qty[s*saot_pkg::WAYS+w] = q;
				tbl_fill[s]++;
				if (tbl_fill[s] > n_fullest) n_fullest = tbl_fill[s];
				n_live++;
				if (n_live > n_peak) n_peak = n_live;
				return w;
			end
		end
		if (n_dropped != '1) n_dropped++;
		return -1;
	endfunction

	function automatic saot_pkg::res_t apply_command(logic [1:0] c, logic [63:0] r,
			logic [31:0] q, logic [63:0] nr, logic [15:0] loc);
		saot_pkg::res_t e;
		int s, w;
		e = '0;
		e.status = saot_pkg::ST_INVALID;
		s = 0;
		if (c == saot_pkg::CMD_INSERT) begin
			if (mdl_fen && loc != mdl_floc) begin
				e.status = saot_pkg::ST_FILTERED;
			end else if (r != 0) begin
				s = set_of(r);
				w = store_entry(s, r, q);
				if (w >= 0) begin
					e.status = saot_pkg::ST_INSERTED;
					e.way_index = 3'(w);
					e.qty_left = q;
				end else begin
					e.status = saot_pkg::ST_OVERFLOW;
				end
			end
		end else if (c == saot_pkg::CMD_DELETE || c == saot_pkg::CMD_DECR) begin
			if (r != 0) begin
				s = set_of(r);
				w = find_way(s, r);
				if (w < 0) begin
					if (n_missed != '1) n_missed++;
					e.status = saot_pkg::ST_MISS;
				end else if (c == saot_pkg::CMD_DELETE) begin
					drop_entry(s, w);
					e.status = saot_pkg::ST_DELETED;
					e.way_index = 3'(w);
				end else begin
					e.way_index = 3'(w);
					if (tbl_qty[s*saot_pkg::WAYS+w] > q) begin
						tbl_qty[s*saot_pkg::WAYS+w] -= q;
						e.qty_left = tbl_qty[s*saot_pkg::WAYS+w];
						e.status = saot_pkg::ST_DECR;
					end else begin
						drop_entry(s, w);
						e.status = saot_pkg::ST_DECR_RM;
					end
				end
			end
		end else if (r != 0 && nr != 0) begin
			s = set_of(r);
			w = find_way(s, r);
			if (w < 0) begin
				if (n_missed != '1) n_missed++;
				e.status = saot_pkg::ST_MISS;
			end else begin
				drop_entry(s, w);
				s = set_of(nr);
				w = store_entry(s, nr, q);
				if (w >= 0) begin
					e.status = saot_pkg::ST_REPLACED;
					e.way_index = 3'(w);
					e.qty_left = q;
				end else begin
					e.status = saot_pkg::ST_REPL_OVF;
				end
			end
		end
		e.set_index = 9'(s);
		e.live_count = 13'((n_live > 8191) ? 8191 : n_live);
		e.peak_count = 13'((n_peak > 8191) ? 8191 : n_peak);
		e.max_set_occupancy = 4'((n_fullest > 15) ? 15 : n_fullest);
		e.overflow_count = n_dropped;
		e.miss_count = n_missed;
		return e;
	endfunction

	task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		saot_pkg::res_t e;
		if (!arst_n) begin
			mdl_hash <= saot_pkg::HASH_FOLD;
			mdl_bits <= 4'd9;
			mdl_fen <= 1'b0;
			mdl_floc <= '0;
			for (int i = 0; i < saot_pkg::NSETS*saot_pkg::WAYS; i++) begin
				tbl_ref[i] = '0;
				tbl_qty[i] = '0;
			end
			for (int i = 0; i < saot_pkg::NSETS; i++) tbl_fill[i] = 0;
			n_live = 0;
			n_peak = 0;
			n_fullest = 0;
			n_dropped = '0;
			n_missed = '0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					saot_pkg::REG_HASH: mdl_hash <= cfg_data[1:0];
					saot_pkg::REG_SETBITS: mdl_bits <= cfg_data[3:0];
					saot_pkg::REG_FEN: mdl_fen <= cfg_data[0];
					saot_pkg::REG_FLOC: mdl_floc <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual status %0d",
						$time, status);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					compare_field("status", e.status, status);
					compare_field("set_index", e.set_index, set_index);
					compare_field("way_index", e.way_index, way_index);
					compare_field("qty_left", e.qty_left, qty_left);
					compare_field("live_count", e.live_count, live_count);
					compare_field("peak_count", e.peak_count, peak_count);
					compare_field("max_set_occupancy", e.max_set_occupancy,
						max_set_occupancy);
					compare_field("overflow_count", e.overflow_count, overflow_count);
					compare_field("miss_count", e.miss_count, miss_count);
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(apply_command(command, order_id, quantity,
					new_ref, locate));
		end
	end
endmodule

/* tb/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] command;
	logic [63:0] order_id, new_ref;
	logic [31:0] quantity;
	logic [15:0] locate;
	logic [3:0] status;
	logic [8:0] set_index;
	logic [2:0] way_index;
	logic [31:0] qty_left, overflow_count, miss_count;
	logic [12:0] live_count, peak_count;
	logic [3:0] max_set_occupancy;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	int fail_count, pending_results;
	bit stimulus_done;
	bit hold_receiver;
	bit held;
	logic [63:0] live_refs [$];

	set_associative_order_table u_dut (.*);

	order_table_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("set_associative_order_table test failed");
		$finish;
	end

	initial begin
		out_ready = 0;
		held = 0;
		wait (arst_n);
		forever begin
			if (hold_receiver && !held) begin
				out_ready <= 0;
				repeat (300) @(posedge clk);
				held = 1;
			end
			repeat ($urandom_range(0, 15) * ($urandom_range(0, 3) != 0)) begin
				out_ready <= 0;
				@(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
		end
	end

	task automatic send_item(logic [1:0] c, logic [63:0] r, logic [31:0] q,
			logic [63:0] nr, logic [15:0] loc);
		in_valid <= 1;
		command <= c;
		order_id <= r;
		quantity <= q;
		new_ref <= nr;
		locate <= loc;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (c == saot_pkg::CMD_INSERT && r != 0) live_refs.push_back(r);
		if ($urandom_range(0, 3) != 0) begin
			in_valid <= 0;
			repeat ($urandom_range(0, 15)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		in_valid <= 0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_ref();
		if (live_refs.size() > 0 && $urandom_range(0, 3) != 0)
			return live_refs[$urandom_range(0, live_refs.size() - 1)];
		return ($urandom_range(0, 1)) ? rand64() : 64'($urandom_range(1, 64));
	endfunction

	task automatic random_phase(int n, bit narrow);
		logic [1:0] c;
		logic [63:0] r;
		for (int i = 0; i < n; i++) begin
			c = 2'($urandom_range(0, 3));
			r = (c == saot_pkg::CMD_INSERT) ?
				(narrow ? 64'($urandom_range(1, 4000)) : rand64()) : pick_ref();
			if ($urandom_range(0, 40) == 0) r = 64'd0;
			send_item(c, r, ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 20),
				($urandom_range(0, 40) == 0) ? 64'd0 : rand64(),
				($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)));
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		command = '0;
		order_id = '0;
		quantity = '0;
		new_ref = '0;
		locate = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		stimulus_done = 0;
		hold_receiver = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_item(saot_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 64'd0,
			16'hFFFF);
		send_item(saot_pkg::CMD_INSERT, 64'd1, 32'd0, 64'd0, 16'd0);
		send_item(saot_pkg::CMD_INSERT, 64'd0, 32'd5, 64'd0, 16'd0);
		send_item(saot_pkg::CMD_DECR, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 64'd0, 16'd0);
		send_item(saot_pkg::CMD_DECR, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 16'd0);
		send_item(saot_pkg::CMD_DECR, 64'd0, 32'd1, 64'd0, 16'd0);
		send_item(saot_pkg::CMD_DELETE, 64'd1, 32'd0, 64'd0, 16'd0);
		send_item(saot_pkg::CMD_DELETE, 64'd1, 32'd0, 64'd0, 16'd0);
		send_item(saot_pkg::CMD_DELETE, 64'd0, 32'd0, 64'd0, 16'd0);
		send_item(saot_pkg::CMD_INSERT, 64'd7, 32'd10, 64'd0, 16'd0);
		send_item(saot_pkg::CMD_INSERT, 64'd7, 32'd20, 64'd0, 16'd0);
		send_item(saot_pkg::CMD_REPLACE, 64'd7, 32'd3, 64'h8000_0000_0000_0000, 16'd0);
		send_item(saot_pkg::CMD_REPLACE, 64'd7, 32'd3, 64'd0, 16'd0);
		send_item(saot_pkg::CMD_REPLACE, 64'd0, 32'd3, 64'd9, 16'd0);
		send_item(saot_pkg::CMD_REPLACE, 64'd12345, 32'd3, 64'd9, 16'd0);

		write_reg(saot_pkg::REG_HASH, 16'd0);
		write_reg(saot_pkg::REG_SETBITS, 16'd0);
		for (int i = 0; i < 20; i++)
			send_item(saot_pkg::CMD_INSERT, 64'(2 * i + 2), 32'(i), 64'd0, 16'd0);
		send_item(saot_pkg::CMD_REPLACE, 64'd2, 32'd1, 64'd4, 16'd0);
		hold_receiver = 1;
		random_phase(120, 1);

		write_reg(saot_pkg::REG_HASH, 16'd1);
		write_reg(saot_pkg::REG_SETBITS, 16'd15);
		write_reg(saot_pkg::REG_FEN, 16'd1);
		write_reg(saot_pkg::REG_FLOC, 16'd2);
		random_phase(150, 0);

		write_reg(saot_pkg::REG_HASH, 16'd3);
		write_reg(saot_pkg::REG_SETBITS, 16'd3);
		write_reg(saot_pkg::REG_FLOC, 16'hFFFF);
		random_phase(100, 1);

		write_reg(saot_pkg::REG_FEN, 16'd0);
		write_reg(saot_pkg::REG_FLOC, 16'd0);
		write_reg(saot_pkg::REG_SETBITS, 16'd9);
		random_phase(150, 0);

		write_reg(saot_pkg::REG_HASH, 16'd2);
		write_reg(saot_pkg::REG_SETBITS, 16'd1);
		random_phase(150, 1);

		in_valid <= 0;
		stimulus_done = 1;
	end

	initial begin
		wait (stimulus_done);
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("set_associative_order_table test passed");
		end else begin
			$display("set_associative_order_table test failed");
		end
		$finish;
	end
endmodule

/* files.f */
hw/rtl/saot_pkg.sv
hw/rtl/saot_front.sv
hw/rtl/saot_hash.sv
hw/rtl/saot_back.sv
hw/rtl/set_associative_order_table.sv
hw/rtl/saot_checker.sv
tb/order_table_checker.sv
tb/tb.sv
